/* src/pfba_pkg.sv */
// ----------------------------------------------------------------------------
// Paged fixed block allocator package
// Shared widths, request and result types, action and status codes, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Fixed field widths.
  localparam int ADDR_W = 10;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 7;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] CNT_MAX   = 7'h7F;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Default geometry for the top level parameters.
  localparam int DEF_UNITS_PER_PAGE = 64;
  localparam int DEF_MAX_PAGES      = 16;

  // Request codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] unit_address;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;
  } out_item_t;

  // Result of the address divider.
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
    logic [CFG_W-1:0]  remainder;
  } div_res_t;

  // Request sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FREE_WB,
    S_INIT,
    S_ALLOC_RD,
    S_ALLOC_LINK,
    S_ALLOC_WB
  } state_e;

endpackage

/* src/pfba_div.sv */
// ----------------------------------------------------------------------------
// Address divider
// Restoring divider that splits a unit address into page and slot, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfba_div
  import pfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [CFG_W-1:0]  divisor,
  output div_res_t          res
);

  localparam int ITER_W = $clog2(ADDR_W + 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [CFG_W-1:0]  dvs_r, dvs_nxt;
  logic [CFG_W:0]    shifted;
  logic [CFG_W:0]    trial;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign shifted = {rem_r, quo_r[ADDR_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = ITER_W'(ADDR_W - 1);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      quo_nxt = {quo_r[ADDR_W-2:0], fits};
      rem_nxt = fits ? trial[CFG_W-1:0] : shifted[CFG_W-1:0];
      cnt_nxt = cnt_r - ITER_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

/* src/pfba_page_store.sv */
// ----------------------------------------------------------------------------
// Page table store
// Per-page free-list head and free count in a synchronous memory, plus one
// flag per page that marks a nonzero count and finds the newest such page.
// ----------------------------------------------------------------------------
module pfba_page_store
  import pfba_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int PAGE_W    = 4,
  parameter int SLOT_W    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [PAGE_W-1:0] rd_page,
  output logic [SLOT_W-1:0] rd_head,
  output logic [CNT_W-1:0]  rd_count,
  input  logic              wr_en,
  input  logic [PAGE_W-1:0] wr_page,
  input  logic [SLOT_W-1:0] wr_head,
  input  logic [CNT_W-1:0]  wr_count,
  output logic              any_free,
  output logic [PAGE_W-1:0] newest_free
);

  logic [SLOT_W+CNT_W-1:0] mem [MAX_PAGES];
  logic [SLOT_W+CNT_W-1:0] rd_data_r;
  logic [MAX_PAGES-1:0]    free_r;

  // Page memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_page] <= {wr_head, wr_count};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_page];
    end
  end

  assign rd_head  = rd_data_r[SLOT_W+CNT_W-1:CNT_W];
  assign rd_count = rd_data_r[CNT_W-1:0];

  // Free flags follow every count write. Pages never opened keep a clear flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
    end else if (wr_en) begin
      free_r[wr_page] <= (wr_count != '0);
    end
  end

  // Priority pick of the highest numbered page that still has free units.
  always_comb begin
    newest_free = '0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      if (free_r[i]) begin
        newest_free = PAGE_W'(i);
      end
    end
  end

  assign any_free = |free_r;

endmodule

/* src/paged_fixed_block_allocator.sv */
// Allocate from an open page reads the page table, then the head's link, then
// writes the page table back; opening a page first walks its links.
// A free runs through the 10-step address divider, then pushes the unit; an
// address outside the open pages is refused when the divider finishes; clear
// rewrites the links of every open page, one link per cycle.
// One request is in flight at a time; the next is accepted in the strobe cycle.
// Reset clears all pages and sets units per page to 64; link memory is not swept.
// ----------------------------------------------------------------------------
// Paged fixed block allocator
// Hands out and takes back fixed-size units kept on per-page free lists held
// in a link memory and a page table memory.
// ----------------------------------------------------------------------------
module paged_fixed_block_allocator
  import pfba_pkg::*;
#(
  parameter int UNITS_PER_PAGE = DEF_UNITS_PER_PAGE,
  parameter int MAX_PAGES      = DEF_MAX_PAGES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SLOT_W     = $clog2(UNITS_PER_PAGE);
  localparam int PAGE_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int OPEN_W     = $clog2(MAX_PAGES + 1);
  localparam int LINK_DEPTH = MAX_PAGES * UNITS_PER_PAGE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int IDX_W      = ((SLOT_W > CFG_W) ? SLOT_W : CFG_W) + 1;
  localparam int CMP_W      = ((ADDR_W > OPEN_W) ? ADDR_W : OPEN_W);
  localparam int GP_W       = PAGE_W + CFG_W;

  state_e            state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_r;
  logic [CFG_W-1:0]  cap;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              clr_mode_r, clr_mode_nxt;
  logic [OPEN_W-1:0] open_r, open_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic              can_open;
  logic              init_last;
  logic              clear_last;
  logic              div_bad;
  logic [IDX_W-1:0]  idx_inc;
  logic [SLOT_W-1:0] init_link;
  logic [GP_W-1:0]   grant_sum;

  logic              pm_rd_en;
  logic [PAGE_W-1:0] pm_rd_page;
  logic [SLOT_W-1:0] pm_head;
  logic [CNT_W-1:0]  pm_count;
  logic              pm_wr_en;
  logic [PAGE_W-1:0] pm_wr_page;
  logic [SLOT_W-1:0] pm_wr_head;
  logic [CNT_W-1:0]  pm_wr_count;
  logic              ps_any_free;
  logic [PAGE_W-1:0] ps_newest;

  logic              div_start;
  div_res_t          div_res;

  logic [SLOT_W-1:0]  link_mem [LINK_DEPTH];
  logic [SLOT_W-1:0]  lk_rd_data_r;
  logic [LINK_AW-1:0] lk_rd_addr;
  logic               lk_wr_en;
  logic [LINK_AW-1:0] lk_wr_addr;
  logic [SLOT_W-1:0]  lk_wr_data;

  // Link memory index of a slot within a page.
  function automatic logic [LINK_AW-1:0] link_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [SLOT_W-1:0] slot);
    link_addr = LINK_AW'(int'(page) * UNITS_PER_PAGE + int'(slot));
  endfunction

  // Effective page capacity: zero acts as one, large values clamp to the page.
  always_comb begin
    if (cfg_r == '0) begin
      cap = CFG_W'(1);
    end else if (int'(cfg_r) > UNITS_PER_PAGE) begin
      cap = CFG_W'(UNITS_PER_PAGE);
    end else begin
      cap = cfg_r;
    end
  end

  // Configuration register. A write never lands in the cycle a request is taken.
  assign cfg_ready = (state_r == S_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // Shared decode terms.
  assign accept     = start && !busy;
  assign can_open   = (int'(open_r) < MAX_PAGES);
  assign idx_inc    = IDX_W'(idx_r) + IDX_W'(1);
  assign init_last  = (idx_inc == IDX_W'(cap));
  assign init_link  = init_last ? '0 : SLOT_W'(idx_inc);
  assign clear_last = ((OPEN_W'(page_r) + OPEN_W'(1)) == open_r);
  assign div_bad    = (CMP_W'(div_res.quotient) >= CMP_W'(open_r));
  assign grant_sum  = GP_W'(page_r) * GP_W'(cap) + GP_W'(slot_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_ALLOC: begin
              if (ps_any_free) begin
                state_nxt = S_ALLOC_LINK;
              end else if (can_open) begin
                state_nxt = S_INIT;
              end
            end
            ACT_FREE:  state_nxt = S_DIV;
            ACT_CLEAR: begin
              if (open_r != '0) begin
                state_nxt = S_INIT;
              end
            end
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_nxt = div_bad ? S_IDLE : S_FREE_WB;
        end
      end
      S_FREE_WB: state_nxt = S_IDLE;
      S_INIT: begin
        if (init_last) begin
          if (!clr_mode_r) begin
            state_nxt = S_ALLOC_RD;
          end else if (clear_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ALLOC_RD:   state_nxt = S_ALLOC_LINK;
      S_ALLOC_LINK: state_nxt = S_ALLOC_WB;
      S_ALLOC_WB:   state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Memory commands and datapath updates.
  always_comb begin
    page_nxt      = page_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    clr_mode_nxt  = clr_mode_r;
    open_nxt      = open_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pm_rd_en      = 1'b0;
    pm_rd_page    = page_r;
    pm_wr_en      = 1'b0;
    pm_wr_page    = page_r;
    pm_wr_head    = '0;
    pm_wr_count   = '0;
    lk_rd_addr    = link_addr(page_r, pm_head);
    lk_wr_en      = 1'b0;
    lk_wr_addr    = link_addr(page_r, idx_r);
    lk_wr_data    = init_link;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_ALLOC: begin
              if (ps_any_free) begin
                pm_rd_en   = 1'b1;
                pm_rd_page = ps_newest;
                page_nxt   = ps_newest;
              end else if (can_open) begin
                page_nxt     = PAGE_W'(open_r);
                idx_nxt      = '0;
                clr_mode_nxt = 1'b0;
              end else begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{status: ST_NO_SPACE, granted_address: '0};
              end
            end
            ACT_FREE: begin
              div_start = 1'b1;
            end
            ACT_CLEAR: begin
              if (open_r != '0) begin
                page_nxt     = '0;
                idx_nxt      = '0;
                clr_mode_nxt = 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{status: ST_DONE, granted_address: '0};
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{status: ST_DONE, granted_address: '0};
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_bad) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: ST_BAD_ADDR, granted_address: '0};
          end else begin
            page_nxt   = PAGE_W'(div_res.quotient);
            slot_nxt   = SLOT_W'(div_res.remainder);
            pm_rd_en   = 1'b1;
            pm_rd_page = PAGE_W'(div_res.quotient);
          end
        end
      end
      S_FREE_WB: begin
        // Push the slot: its link takes the old head.
        lk_wr_en      = 1'b1;
        lk_wr_addr    = link_addr(page_r, slot_r);
        lk_wr_data    = pm_head;
        pm_wr_en      = 1'b1;
        pm_wr_head    = slot_r;
        pm_wr_count   = (pm_count != CNT_MAX) ? pm_count + CNT_W'(1) : pm_count;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_DONE, granted_address: '0};
      end
      S_INIT: begin
        // Chain slot i to slot i+1, the last slot back to slot 0.
        lk_wr_en = 1'b1;
        idx_nxt  = SLOT_W'(idx_inc);
        if (init_last) begin
          pm_wr_en    = 1'b1;
          pm_wr_head  = '0;
          pm_wr_count = cap;
          idx_nxt     = '0;
          if (!clr_mode_r) begin
            open_nxt = open_r + OPEN_W'(1);
          end else if (clear_last) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: ST_DONE, granted_address: '0};
          end else begin
            page_nxt = page_r + PAGE_W'(1);
          end
        end
      end
      S_ALLOC_RD: begin
        pm_rd_en = 1'b1;
      end
      S_ALLOC_LINK: begin
        slot_nxt = pm_head;
        cnt_nxt  = pm_count;
      end
      S_ALLOC_WB: begin
        // Pop the head: the new head is the popped slot's link.
        pm_wr_en      = 1'b1;
        pm_wr_head    = lk_rd_data_r;
        pm_wr_count   = cnt_r - CNT_W'(1);
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_DONE, granted_address: ADDR_W'(grant_sum)};
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= '0;
      out_valid_r <= 1'b0;
      clr_mode_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
      clr_mode_r  <= clr_mode_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  // Link memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (lk_wr_en) begin
      link_mem[lk_wr_addr] <= lk_wr_data;
    end
    lk_rd_data_r <= link_mem[lk_rd_addr];
  end

  pfba_page_store #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_W    (PAGE_W),
    .SLOT_W    (SLOT_W)
  ) u_page_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (pm_rd_en),
    .rd_page     (pm_rd_page),
    .rd_head     (pm_head),
    .rd_count    (pm_count),
    .wr_en       (pm_wr_en),
    .wr_page     (pm_wr_page),
    .wr_head     (pm_wr_head),
    .wr_count    (pm_wr_count),
    .any_free    (ps_any_free),
    .newest_free (ps_newest)
  );

  pfba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_item.unit_address),
    .divisor  (cap),
    .res      (div_res)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  // A full allocator answers out of space in the next cycle.
  a_no_space: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.action == ACT_ALLOC) && !ps_any_free && !can_open)
      |=> (out_valid && (out_item.status == ST_NO_SPACE)))
    else $error("full allocator did not report out of space");

  // The link walk never runs past the page capacity.
  a_init_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> (IDX_W'(idx_r) < IDX_W'(cap)))
    else $error("link walk index beyond page capacity");

  // A page chosen for allocation always has a free unit.
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC_LINK) |-> (pm_count != '0))
    else $error("allocation from a page with no free unit");

  // The open page count only moves at the end of a page open.
  a_open_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (open_r != $past(open_r)))
      |-> (($past(state_r) == S_INIT) && !$past(clr_mode_r)))
    else $error("open page count changed outside a page open");

  // The divider only finishes while a free request waits on it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider result outside a free request");
`endif

endmodule

/* tb/paged_fixed_block_allocator_test.sv */
// ----------------------------------------------------------------------------
// Paged fixed block allocator testbench
// Sends allocate, free, clear and no-op requests through the start/busy
// command port in random bursts. A request-level predictor keeps its own copy of
// the page table and link memory, and every result strobe is checked against
// the oldest predicted result. The units-per-page register is rewritten
// between phases, including out-of-range values and changes while pages are
// open.
// ----------------------------------------------------------------------------
module paged_fixed_block_allocator_test;
  import pfba_pkg::*;

  localparam int UPP             = DEF_UNITS_PER_PAGE;
  localparam int NPAGES          = DEF_MAX_PAGES;
  localparam int SLOT_W          = $clog2(UPP);
  localparam int CYCLE_LIMIT     = 8_000_000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 11;
  localparam int SAT_FREES       = 70;

  // One predicted result, tagged with the request that caused it.
  typedef struct {
    out_item_t res;
    action_e   act;
  } awaited_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_item_t         in_item   = '0;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  paged_fixed_block_allocator #(
    .UNITS_PER_PAGE (UPP),
    .MAX_PAGES      (NPAGES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Predicted allocator state.
  logic [SLOT_W-1:0] link_mem  [UPP*NPAGES] = '{default: '0};
  logic [SLOT_W-1:0] head_slot [NPAGES]     = '{default: '0};
  logic [CNT_W-1:0]  free_cnt  [NPAGES]     = '{default: '0};
  int                open_pages = 0;
  logic [CFG_W-1:0]  upp_reg    = CFG_RESET;

  in_item_t          pending_reqs[$];
  awaited_t          awaited_results[$];
  logic [ADDR_W-1:0] live_units[$];
  int                failures    = 0;
  int                cycle_count = 0;
  int                burst_left  = 1;
  int                gap_left    = 0;

  // Page capacity in use: zero acts as one, values above the page size clip.
  function automatic int effective_capacity();
    if (upp_reg == 0) return 1;
    if (upp_reg > UPP) return UPP;
    return int'(upp_reg);
  endfunction

  // Fresh page: full count, head at slot 0, slots chained in order and wrapped.
  function automatic void init_page(int page, int cap);
    free_cnt[page]  = CNT_W'(cap);
    head_slot[page] = '0;
    for (int i = 0; i < cap; i++) begin
      link_mem[page*UPP + i] = SLOT_W'((i + 1) % cap);
    end
  endfunction

  // Applies one request to the predicted state and returns its result.
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t res;
    int        cap;
    int        p;
    int        slot;
    int        page;
    bit        found;
    cap = effective_capacity();
    res = '0;
    res.status = ST_DONE;
    case (action_e'(req.action))
      ACT_ALLOC: begin
        // Newest page with a free unit first, then a new page if allowed.
        p = open_pages;
        found = 1'b0;
        while (p > 0 && !found) begin
          p--;
          found = (free_cnt[p] != 0);
        end
        if (!found && open_pages < NPAGES) begin
          p = open_pages;
          init_page(p, cap);
          open_pages++;
          found = 1'b1;
        end
        if (found) begin
          slot = int'(head_slot[p]);
          free_cnt[p] = free_cnt[p] - 1'b1;
          head_slot[p] = link_mem[p*UPP + slot];
          res.granted_address = ADDR_W'(p*cap + slot);
        end else begin
          res.status = ST_NO_SPACE;
        end
      end
      ACT_FREE: begin
        page = int'(req.unit_address) / cap;
        slot = int'(req.unit_address) % cap;
        if (page >= open_pages) begin
          res.status = ST_BAD_ADDR;
        end else begin
          // No double-free check; the count saturates.
          link_mem[page*UPP + slot] = head_slot[page];
          head_slot[page] = SLOT_W'(slot);
          if (free_cnt[page] != CNT_MAX) free_cnt[page] = free_cnt[page] + 1'b1;
        end
      end
      ACT_CLEAR: begin
        for (p = 0; p < open_pages; p++) init_page(p, cap);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Driver: sends pending requests in bursts with random gaps between them.
  always @(posedge clk) begin
    awaited_t rec;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rec.act = action_e'(in_item.action);
        rec.res = serve_request(in_item);
        awaited_results.push_back(rec);
        void'(pending_reqs.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        start   <= 1'b1;
        in_item <= pending_reqs[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result strobe against the oldest prediction.
  always @(posedge clk) begin
    awaited_t rec;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: status %0d granted_address %0d",
               out_item.status, out_item.granted_address);
        failures++;
      end else begin
        rec = awaited_results.pop_front();
        if (out_item.status !== rec.res.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 rec.res.status, out_item.status);
          failures++;
        end
        if (out_item.granted_address !== rec.res.granted_address) begin
          $error("granted_address mismatch: expected %0d, actual %0d",
                 rec.res.granted_address, out_item.granted_address);
          failures++;
        end
        // Track handed-out units so later frees are mostly well formed.
        if (rec.act == ACT_CLEAR) begin
          live_units.delete();
        end else if (rec.act == ACT_ALLOC && rec.res.status == ST_DONE) begin
          live_units.push_back(rec.res.granted_address);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Adds one request, keeping the pending queue short so that the random
  // choices follow the current state.
  task automatic queue_request(input action_e act, input logic [ADDR_W-1:0] addr);
    in_item_t req;
    req.action       = act;
    req.unit_address = addr;
    do @(negedge clk); while (pending_reqs.size() >= 2);
    pending_reqs.push_back(req);
  endtask

  // Mostly allocates and frees of live units, plus stray addresses, clears and no-ops.
  task automatic queue_random_request();
    int                roll;
    int                idx;
    int                boundary;
    logic [ADDR_W-1:0] addr;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      queue_request(ACT_ALLOC, ADDR_W'($urandom_range(0, 1023)));
    end else if (roll < 80 && live_units.size() != 0) begin
      idx  = $urandom_range(0, live_units.size() - 1);
      addr = live_units[idx];
      // Now and then the unit stays listed and gets freed twice.
      if (roll % 5 != 0) live_units.delete(idx);
      queue_request(ACT_FREE, addr);
    end else if (roll < 88) begin
      queue_request(ACT_FREE, ADDR_W'($urandom_range(0, 1023)));
    end else if (roll < 93) begin
      // Addresses just around the end of the open pages.
      boundary = open_pages * effective_capacity() - 2 + $urandom_range(0, 3);
      if (boundary < 0) boundary = 0;
      if (boundary > 1023) boundary = 1023;
      queue_request(ACT_FREE, ADDR_W'(boundary));
    end else if (roll < 96) begin
      queue_request(ACT_CLEAR, ADDR_W'($urandom_range(0, 1023)));
    end else begin
      queue_request(ACT_NONE, ADDR_W'($urandom_range(0, 1023)));
    end
  endtask

  // Holds off until every request has been sent and answered.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || awaited_results.size() != 0 || start || busy);
  endtask

  // Writes the units-per-page register while the allocator is idle.
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    upp_reg = value;
    live_units.delete();
  endtask

  // Stimulus sequence.
  initial begin
    logic [CFG_W-1:0] phase_caps [NUM_PHASES];
    phase_caps = '{7'd64, 7'd127, 7'd65, 7'd32, 7'd1, 7'd16, 7'd7, 7'd4, 7'd2, 7'd0, 7'd1};
    phase_caps[4] = CFG_W'($urandom_range(1, 64));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: page open, double free, frees outside open pages, no-op, clear.
    queue_request(ACT_ALLOC, 10'd0);
    queue_request(ACT_ALLOC, 10'h3FF);
    queue_request(ACT_FREE, 10'd1);
    queue_request(ACT_FREE, 10'd1);
    queue_request(ACT_FREE, 10'd64);
    queue_request(ACT_FREE, 10'h3FF);
    queue_request(ACT_NONE, 10'h3FF);
    queue_request(ACT_ALLOC, 10'h155);
    queue_request(ACT_CLEAR, 10'h2AA);
    queue_request(ACT_ALLOC, 10'd0);

    // Random phases, each at its own page capacity; open pages carry over.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      if (ph == 0) begin
        // Push slot 0 of page 0 over and over until the free count saturates.
        queue_request(ACT_CLEAR, 10'd0);
        repeat (SAT_FREES) queue_request(ACT_FREE, 10'd0);
        repeat (SAT_FREES) queue_request(ACT_ALLOC, ADDR_W'($urandom_range(0, 1023)));
      end
      repeat (ITEMS_PER_PHASE) queue_random_request();
    end

    // Page limit: one unit per page, every page refilled, then one too many.
    write_capacity(7'd1);
    queue_request(ACT_CLEAR, 10'd0);
    repeat (NPAGES + 1) queue_request(ACT_ALLOC, 10'd0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
